// ===== src/blpc_pkg.sv =====
// shared types and constants for the button led pattern controller
package blpc_pkg;

    // debounce history length default
    localparam int DEBOUNCE_LEN_DEF = 9;

    // field and register widths
    localparam int TICK_W       = 13;
    localparam int HALF_W       = 12;
    localparam int WAKE_W       = 3;
    localparam int LED_W        = 2;
    localparam int MODE_W       = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int TDATA_W      = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [WAKE_W-1:0] WAKE_COUNT_RST  = 3'd5;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 12'd500;
    localparam logic [TICK_W-1:0] WRAP_LIMIT_RST  = 13'd5000;

    // debounce history reset pattern, cut to the history length
    localparam logic [15:0] HIST_RESET_VAL = 16'h000F;

    // strobe pattern breakpoints in ticks
    localparam logic [TICK_W-1:0] STROBE_ON1    = 13'd150;
    localparam logic [TICK_W-1:0] STROBE_OFF1   = 13'd300;
    localparam logic [TICK_W-1:0] STROBE_ON2    = 13'd450;
    localparam logic [TICK_W-1:0] STROBE_OFF2   = 13'd600;
    localparam logic [TICK_W-1:0] STROBE_ON3    = 13'd750;
    localparam logic [TICK_W-1:0] STROBE_OFF3   = 13'd900;
    localparam logic [TICK_W-1:0] STROBE_PERIOD = 13'd2000;

    // led drive codes
    localparam logic [LED_W-1:0] LED_NONE = 2'd0;
    localparam logic [LED_W-1:0] LED_ONE  = 2'd1;
    localparam logic [LED_W-1:0] LED_TWO  = 2'd2;
    localparam logic [LED_W-1:0] LED_BOTH = 2'd3;

    // operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 3'd0,
        MODE_ON        = 3'd1,
        MODE_ALTERNATE = 3'd2,
        MODE_STROBE    = 3'd3,
        MODE_BLINK     = 3'd4
    } mode_t;

endpackage

// ===== src/button_led_pattern_controller.sv =====
// button led pattern controller: debounce, mode sequencing and led drive
// flow: an accepted sample beat waits in the input register until its result is registered in the result register
// throughput: one sample beat per cycle while m_tready keeps up; a held result does not stall the input
//   register until it is itself full, so the pipe runs at one beat per clock unless the result is held
// reset: aresetn low at a clock edge returns mode to off, history to its idle
//   pattern, configuration to its defaults and empties both pipeline registers
module button_led_pattern_controller #(
    parameter int DEBOUNCE_LEN = blpc_pkg::DEBOUNCE_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [blpc_pkg::TDATA_W-1:0]        s_tdata,   // pin_level, tick, zero pad
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [blpc_pkg::TDATA_W-1:0]        m_tdata,   // led_drive, mode, asleep, pad
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [blpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [blpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [DEBOUNCE_LEN-1:0] HistReset   =
        DEBOUNCE_LEN'(blpc_pkg::HIST_RESET_VAL);
    localparam logic [DEBOUNCE_LEN-1:0] HistRelease =
        {1'b0, {(DEBOUNCE_LEN-1){1'b1}}};

    // configuration registers
    logic [blpc_pkg::WAKE_W-1:0] wake_count_reg;
    logic [blpc_pkg::HALF_W-1:0] half_period_reg;
    logic [blpc_pkg::TICK_W-1:0] wrap_limit_reg;

    // input register
    logic in_valid_reg;
    logic in_pin_reg;
    logic in_tick_reg;

    // controller state
    logic [DEBOUNCE_LEN-1:0]     hist_reg,   hist_next;
    logic                        armed_reg,  armed_next;
    blpc_pkg::mode_t             mode_reg,   mode_next;
    logic [blpc_pkg::TICK_W-1:0] tick_reg,   tick_next;
    logic [blpc_pkg::WAKE_W-1:0] wake_reg,   wake_next;
    logic                        wrel_reg,   wrel_next;

    // result register
    logic                        out_valid_reg;
    logic [blpc_pkg::LED_W-1:0]  out_led_reg;
    logic [blpc_pkg::MODE_W-1:0] out_mode_reg;
    logic                        out_asleep_reg;

    logic                        advance;
    logic [blpc_pkg::TICK_W:0]   tick_inc;
    logic [blpc_pkg::TICK_W:0]   twice_half;
    logic [blpc_pkg::TICK_W-1:0] half_ext;
    logic [blpc_pkg::LED_W-1:0]  led_next;
    logic                        asleep_next;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_asleep_reg, out_mode_reg, out_led_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wake_count_reg  <= blpc_pkg::WAKE_COUNT_RST;
            half_period_reg <= blpc_pkg::HALF_PERIOD_RST;
            wrap_limit_reg  <= blpc_pkg::WRAP_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                blpc_pkg::REG_WAKE_COUNT:  wake_count_reg  <= cfg_data[blpc_pkg::WAKE_W-1:0];
                blpc_pkg::REG_HALF_PERIOD: half_period_reg <= cfg_data[blpc_pkg::HALF_W-1:0];
                blpc_pkg::REG_WRAP_LIMIT:  wrap_limit_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pin_reg  <= s_tdata[0];
            in_tick_reg <= s_tdata[1];
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= HistReset;
            armed_reg <= 1'b0;
            mode_reg  <= blpc_pkg::MODE_OFF;
            tick_reg  <= '0;
            wake_reg  <= blpc_pkg::WAKE_COUNT_RST;
            wrel_reg  <= 1'b0;
        end else if (advance) begin
            hist_reg  <= hist_next;
            armed_reg <= armed_next;
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            wake_reg  <= wake_next;
            wrel_reg  <= wrel_next;
        end
    end

    assign tick_inc   = {1'b0, tick_reg} + 14'd1;
    assign half_ext   = {1'b0, half_period_reg};
    assign twice_half = {1'b0, half_period_reg, 1'b0};

    // next state and led drive for the sample in the input register
    always_comb begin
        hist_next   = hist_reg;
        armed_next  = armed_reg;
        mode_next   = mode_reg;
        tick_next   = tick_reg;
        wake_next   = wake_reg;
        wrel_next   = wrel_reg;
        led_next    = blpc_pkg::LED_NONE;
        asleep_next = 1'b0;

        // tick counter advance and wrap
        if (in_tick_reg) begin
            if (tick_inc >= {1'b0, wrap_limit_reg}) begin
                tick_next = '0;
            end else begin
                tick_next = tick_inc[blpc_pkg::TICK_W-1:0];
            end
        end

        if (mode_reg == blpc_pkg::MODE_OFF) begin
            // asleep: wake countdown, then wait for release
            if (wrel_reg) begin
                if (in_pin_reg) begin
                    mode_next = blpc_pkg::MODE_ON;
                    wrel_next = 1'b0;
                end else begin
                    asleep_next = 1'b1;
                end
            end else begin
                if (in_pin_reg) begin
                    wake_next = wake_count_reg;
                end else if (wake_reg <= 3'd1) begin
                    wake_next = '0;
                    wrel_next = 1'b1;
                end else begin
                    wake_next = wake_reg - 3'd1;
                end
                asleep_next = 1'b1;
            end
        end else begin
            // debounce: all low arms, low then highs releases
            hist_next = {hist_reg[DEBOUNCE_LEN-2:0], in_pin_reg};
            if (hist_next == '0) begin
                armed_next = 1'b1;
            end else if (hist_next == HistRelease) begin
                if (armed_reg) begin
                    case (mode_reg)
                        blpc_pkg::MODE_ON:        mode_next = blpc_pkg::MODE_ALTERNATE;
                        blpc_pkg::MODE_ALTERNATE: mode_next = blpc_pkg::MODE_STROBE;
                        blpc_pkg::MODE_STROBE:    mode_next = blpc_pkg::MODE_BLINK;
                        default:                  mode_next = blpc_pkg::MODE_OFF;
                    endcase
                end
                armed_next = 1'b0;
                tick_next  = '0;
            end

            // led pattern from the new mode and tick count
            case (mode_next)
                blpc_pkg::MODE_ON: begin
                    led_next = blpc_pkg::LED_BOTH;
                end
                blpc_pkg::MODE_ALTERNATE: begin
                    if (tick_next < half_ext) begin
                        led_next = blpc_pkg::LED_ONE;
                    end else begin
                        led_next = blpc_pkg::LED_TWO;
                        if ({1'b0, tick_next} >= twice_half) begin
                            tick_next = '0;
                        end
                    end
                end
                blpc_pkg::MODE_STROBE: begin
                    if (tick_next < blpc_pkg::STROBE_ON1 ||
                        (tick_next > blpc_pkg::STROBE_OFF1 && tick_next < blpc_pkg::STROBE_ON2) ||
                        (tick_next > blpc_pkg::STROBE_OFF2 && tick_next < blpc_pkg::STROBE_ON3) ||
                        tick_next > blpc_pkg::STROBE_OFF3) begin
                        led_next = blpc_pkg::LED_NONE;
                        if (tick_next >= blpc_pkg::STROBE_PERIOD) begin
                            tick_next = '0;
                        end
                    end else begin
                        led_next = blpc_pkg::LED_BOTH;
                    end
                end
                blpc_pkg::MODE_BLINK: begin
                    if (tick_next < half_ext) begin
                        led_next = blpc_pkg::LED_NONE;
                    end else begin
                        led_next = blpc_pkg::LED_BOTH;
                        if ({1'b0, tick_next} >= twice_half) begin
                            tick_next = '0;
                        end
                    end
                end
                default: begin
                    // release into off mode
                    mode_next   = blpc_pkg::MODE_OFF;
                    wake_next   = wake_count_reg;
                    wrel_next   = 1'b0;
                    led_next    = blpc_pkg::LED_NONE;
                    asleep_next = 1'b1;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_led_reg    <= led_next;
            out_mode_reg   <= blpc_pkg::MODE_W'(mode_next);
            out_asleep_reg <= asleep_next;
        end
    end

endmodule

// ===== src/blpc_checker.sv =====
// port level checks for the button led pattern controller, with its bind
module blpc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [blpc_pkg::TDATA_W-1:0]     m_tdata
);

    // no result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    // reported mode stays within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:2] <= blpc_pkg::MODE_BLINK)
        else $error("reported mode out of range");

    // asleep is only reported in off mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4:2] == blpc_pkg::MODE_OFF)
        else $error("asleep reported outside off mode");

    // off mode never lights an led
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:2] == blpc_pkg::MODE_OFF |-> m_tdata[1:0] == blpc_pkg::LED_NONE)
        else $error("led driven in off mode");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind button_led_pattern_controller blpc_checker u_blpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_button_led_pattern_controller.sv =====
// self-checking testbench for the button led pattern controller
`timescale 1ns / 1ps

module tb_button_led_pattern_controller;

    localparam int HIST_LEN = blpc_pkg::DEBOUNCE_LEN_DEF;
    localparam logic [HIST_LEN-1:0] HIST_IDLE = blpc_pkg::HIST_RESET_VAL[HIST_LEN-1:0];
    localparam logic [HIST_LEN-1:0] HIST_RELEASE = {1'b0, {(HIST_LEN-1){1'b1}}};
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_AFTER  = 200;

    // one result beat: led drive, mode and sleep flag
    typedef struct packed {
        logic [blpc_pkg::LED_W-1:0]  led;
        logic [blpc_pkg::MODE_W-1:0] mode;
        logic                        asleep;
    } led_state_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [blpc_pkg::TDATA_W-1:0] s_tdata = '0;   // pin_level, tick, zero pad
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [blpc_pkg::TDATA_W-1:0] m_tdata;        // led_drive[1:0], current_mode[4:2], asleep[5]
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [blpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [blpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // samples waiting to be sent, {tick, pin}
    logic [1:0] pending_samples[$];
    led_state_t expected_led_states[$];

    // predictor state and configuration copy
    logic [HIST_LEN-1:0]           hist_q;
    logic                          armed_q;
    blpc_pkg::mode_t               mode_q;
    logic [blpc_pkg::TICK_W-1:0]   ticks_q;
    logic [blpc_pkg::WAKE_W-1:0]   wake_left_q;
    logic                          wait_rel_q;
    logic [blpc_pkg::WAKE_W-1:0]   wake_cfg;
    logic [blpc_pkg::HALF_W-1:0]   half_cfg;
    logic [blpc_pkg::TICK_W-1:0]   wrap_cfg;

    int idle_phase = 0;
    int samples_sent = 0;
    int beats_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    button_led_pattern_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predict the result of one sample and advance the predictor state
    task automatic next_led_state(input logic pin, input logic tick, output led_state_t res);
        int unsigned n;
        int unsigned h;
        int unsigned t;
        logic [blpc_pkg::LED_W-1:0] led;
        logic sleep;
        led = blpc_pkg::LED_NONE;
        sleep = 1'b0;
        // tick counter first
        if (tick) begin
            n = ticks_q + 1;
            ticks_q = (n >= wrap_cfg) ? '0 : n[blpc_pkg::TICK_W-1:0];
        end
        if (mode_q == blpc_pkg::MODE_OFF) begin
            // asleep: count lows to wake, then wait for release
            if (wait_rel_q) begin
                if (pin) begin
                    mode_q = blpc_pkg::MODE_ON;
                    wait_rel_q = 1'b0;
                end else begin
                    sleep = 1'b1;
                end
            end else begin
                if (pin)
                    wake_left_q = wake_cfg;
                else if (wake_left_q <= 1) begin
                    wake_left_q = '0;
                    wait_rel_q = 1'b1;
                end else
                    wake_left_q = wake_left_q - 1'b1;
                sleep = 1'b1;
            end
        end else begin
            // debounce history, press arm and release
            hist_q = {hist_q[HIST_LEN-2:0], pin};
            if (hist_q == '0) begin
                armed_q = 1'b1;
            end else if (hist_q == HIST_RELEASE) begin
                if (armed_q)
                    mode_q = (mode_q == blpc_pkg::MODE_BLINK) ? blpc_pkg::MODE_OFF :
                             blpc_pkg::mode_t'(mode_q + 1'b1);
                armed_q = 1'b0;
                ticks_q = '0;
            end
            h = half_cfg;
            t = ticks_q;
            // led pattern per mode
            case (mode_q)
                blpc_pkg::MODE_ON: begin
                    led = blpc_pkg::LED_BOTH;
                end
                blpc_pkg::MODE_ALTERNATE: begin
                    if (t < h) begin
                        led = blpc_pkg::LED_ONE;
                    end else begin
                        led = blpc_pkg::LED_TWO;
                        if (t >= 2 * h)
                            ticks_q = '0;
                    end
                end
                blpc_pkg::MODE_STROBE: begin
                    if (t < blpc_pkg::STROBE_ON1 ||
                        (t > blpc_pkg::STROBE_OFF1 && t < blpc_pkg::STROBE_ON2) ||
                        (t > blpc_pkg::STROBE_OFF2 && t < blpc_pkg::STROBE_ON3) ||
                        t > blpc_pkg::STROBE_OFF3) begin
                        led = blpc_pkg::LED_NONE;
                        if (t >= blpc_pkg::STROBE_PERIOD)
                            ticks_q = '0;
                    end else begin
                        led = blpc_pkg::LED_BOTH;
                    end
                end
                blpc_pkg::MODE_BLINK: begin
                    if (t < h) begin
                        led = blpc_pkg::LED_NONE;
                    end else begin
                        led = blpc_pkg::LED_BOTH;
                        if (t >= 2 * h)
                            ticks_q = '0;
                    end
                end
                default: begin
                    mode_q = blpc_pkg::MODE_OFF;
                    wake_left_q = wake_cfg;
                    wait_rel_q = 1'b0;
                    led = blpc_pkg::LED_NONE;
                    sleep = 1'b1;
                end
            endcase
        end
        res.led = led;
        res.mode = mode_q;
        res.asleep = sleep;
    endtask

    // sample driver
    always @(posedge aclk) begin : drive_blk
        led_state_t res;
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 74 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                next_led_state(s_tdata[0], s_tdata[1], res);
                expected_led_states.push_back(res);
                samples_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered beat
            end else if (pending_samples.size() > 0 && $urandom_range(99) >= gap_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {{(blpc_pkg::TDATA_W-2){1'b0}}, pending_samples.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin : check_blk
        led_state_t want;
        led_state_t got;
        int stall_pct;
        stall_pct = (idle_phase == 0) ? 74 : (idle_phase == 1) ? 36 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.led = m_tdata[1:0];
                got.mode = m_tdata[4:2];
                got.asleep = m_tdata[5];
                if (expected_led_states.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result beat: led %0d mode %0d asleep %0d",
                                 got.led, got.mode, got.asleep);
                end else begin
                    want = expected_led_states.pop_front();
                    if (got.led !== want.led || got.mode !== want.mode ||
                        got.asleep !== want.asleep) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"beat %0d: expected led %0d mode %0d asleep %0d, ",
                                      "got led %0d mode %0d asleep %0d"},
                                     beats_checked, want.led, want.mode, want.asleep,
                                     got.led, got.mode, got.asleep);
                    end
                end
                beats_checked++;
            end
            // one long receiver hold-off to back the pipe up
            if (!hold_done && beats_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // wait until every queued sample has been sent and answered
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_samples.size() > 0 || s_tvalid || expected_led_states.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // one register write beat, mirrored into the predictor
    task automatic write_reg(input logic [blpc_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[blpc_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            blpc_pkg::REG_WAKE_COUNT:  wake_cfg = val[blpc_pkg::WAKE_W-1:0];
            blpc_pkg::REG_HALF_PERIOD: half_cfg = val[blpc_pkg::HALF_W-1:0];
            blpc_pkg::REG_WRAP_LIMIT:  wrap_cfg = val[blpc_pkg::TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned wake, input int unsigned half,
                              input int unsigned wrap);
        write_reg(blpc_pkg::REG_WAKE_COUNT, wake);
        write_reg(blpc_pkg::REG_HALF_PERIOD, half);
        write_reg(blpc_pkg::REG_WRAP_LIMIT, wrap);
        settings_used++;
    endtask

    function automatic void push_run(input logic pin, input int len, input int tick_pct);
        for (int i = 0; i < len; i++)
            pending_samples.push_back({logic'($urandom_range(99) < tick_pct), pin});
    endfunction

    // one random segment: press, release, hold or noise; returns its length
    function automatic int push_segment();
        int kind;
        int len;
        kind = $urandom_range(9);
        if (kind <= 3) begin
            len = $urandom_range(9, 14);
            push_run(1'b0, len, 50);
        end else if (kind <= 6) begin
            len = $urandom_range(8, 12);
            push_run(1'b1, len, 50);
        end else if (kind <= 8) begin
            len = $urandom_range(1, 40);
            push_run(1'b1, len, 75);
        end else begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                pending_samples.push_back(2'($urandom_range(3)));
        end
        return len;
    endfunction

    initial begin
        int unsigned wake_tab[6] = '{5, 7, 1, 0, 3, 2};
        int unsigned half_tab[6] = '{500, 4095, 1, 3, 7, 12};
        int unsigned wrap_tab[6] = '{5000, 8191, 1, 0, 40, 8191};
        int count;
        int tries;
        // predictor reset state
        wake_cfg = blpc_pkg::WAKE_COUNT_RST;
        half_cfg = blpc_pkg::HALF_PERIOD_RST;
        wrap_cfg = blpc_pkg::WRAP_LIMIT_RST;
        hist_q = HIST_IDLE;
        armed_q = 1'b0;
        mode_q = blpc_pkg::MODE_OFF;
        ticks_q = '0;
        wake_left_q = blpc_pkg::WAKE_COUNT_RST;
        wait_rel_q = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fast wake into on mode, with a short half period set
        set_config(1, 2, 8191);
        pending_samples.push_back(2'b10);
        pending_samples.push_back(2'b00);
        pending_samples.push_back(2'b11);
        for (int i = 0; i < 9; i++)
            pending_samples.push_back({logic'(i[0]), 1'b0});
        for (int i = 0; i < 8; i++)
            pending_samples.push_back({logic'(i[0]), 1'b1});
        for (int i = 0; i < 4; i++)
            pending_samples.push_back(2'b11);
        wait_idle();

        // random phases, each under its own setting
        for (int p = 0; p < 6; p++) begin
            idle_phase = p / 2;
            set_config(wake_tab[p], half_tab[p], wrap_tab[p]);
            count = 0;
            while (count < 40)
                count += push_segment();
            // sender pauses here until every result has come
            wait_idle();
        end

        // strobe sweep past the last strobe breakpoint
        set_config(4, 37, 8191);
        tries = 0;
        while (mode_q != blpc_pkg::MODE_STROBE && tries < 12) begin
            push_run(1'b0, 10, 0);
            push_run(1'b1, 9, 0);
            wait_idle();
            tries++;
        end
        push_run(1'b1, 920, 100);
        wait_idle();

        repeat (10) @(posedge aclk);
        $display("sent %0d sample beats and checked %0d result beats under %0d settings",
                 samples_sent, beats_checked, settings_used);
        $display("covered wake, press and release sequences, all modes and %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_led_states.size() == 0) begin
            $display("button_led_pattern_controller test passed");
        end else begin
            $display("button_led_pattern_controller test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("button_led_pattern_controller test failed");
        $finish;
    end

endmodule
